@@ hdl/lmc_pkg.sv @@
package lmc_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_STEP  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        OP_HLT = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_STA = 4'd3,
        OP_LDA = 4'd5,
        OP_BRA = 4'd6,
        OP_BRZ = 4'd7,
        OP_BRP = 4'd8,
        OP_IO  = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_OPER
    } t_state;

    localparam int unsigned INS_LIMIT    = 1000;
    localparam int unsigned DIGIT_BASE   = 100;
    localparam int unsigned DIV100_MUL   = 41;
    localparam int unsigned DIV100_SHIFT = 12;
    localparam logic [6:0]  ADDR_HALT    = 7'd0;
    localparam logic [6:0]  ADDR_INPUT   = 7'd1;
    localparam logic [6:0]  ADDR_OUTPUT  = 7'd2;

endpackage

@@ hdl/lmc_ram.sv @@
module lmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_q;

endmodule

@@ hdl/little_man_computer_core_unit.sv @@
// Little Man Computer core: mailboxes live in a single synchronous RAM with one write and
// one read port, beside the accumulator, program counter and halt flag. Each item carries
// a request in tuser: load a mailbox, start (clear pc, accumulator and halt flag), or
// execute one instruction. Load, start and idle requests finish in the fetch state; a step
// reads its operand in a following operand state over the shared RAM read port. The next
// item is accepted in the cycle the current one finishes, so loads run at one item per
// clock while results are taken; steps hold the next item back through the operand state.
// Each item gives exactly one result, held in an output register; an item cannot finish,
// and so the next one is not accepted, while that register holds a result the consumer has
// not yet taken. Mailboxes read as zero until written after reset, with no clearing pass.
module little_man_computer_core_unit
    import lmc_pkg::*;
#(
    parameter int MAILBOXES = 100,
    parameter int WORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // mailbox[6:0], word[22:7], zero[23]
    input  logic [1:0]  i_s_tuser,  // req_type[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,  // out_value, halted, bad_code, next_pc, accum_now, zeros
    output logic [0:0]  o_m_tuser   // out_valid[0]
);

    localparam int ADDR_W = $clog2(MAILBOXES);

    t_state                r_state, n_state;
    logic [1:0]            r_req;
    logic [6:0]            r_box;
    logic signed [15:0]    r_word;
    logic [WORD_BITS-1:0]  r_acc, n_acc;
    logic [ADDR_W-1:0]     r_pc, n_pc;
    logic                  r_halt, n_halt;
    logic [MAILBOXES-1:0]  r_vld;

    logic [3:0]            r_op;
    logic [6:0]            r_a;
    logic                  r_a_ok;
    logic                  r_dec_bad;

    logic                  r_fwd_hit;
    logic [WORD_BITS-1:0]  r_fwd_data;
    logic                  r_rd_vld;
    logic [WORD_BITS-1:0]  ram_q;
    logic [WORD_BITS-1:0]  mem_q;

    logic                  we, re;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [WORD_BITS-1:0]  wdata;

    logic                  out_free, go_oper, done, in_ready, accept;
    logic [9:0]            dec_ins;
    logic [15:0]           dec_prod;
    logic [3:0]            dec_op;
    logic [9:0]            dec_rem;
    logic [6:0]            dec_a;
    logic                  dec_a_ok;
    logic                  dec_bad;

    logic [WORD_BITS-1:0]  opnd;
    logic [ADDR_W-1:0]     seq_pc, tgt_pc;
    logic [WORD_BITS-1:0]  ex_acc;
    logic [ADDR_W-1:0]     ex_pc;
    logic                  ex_halt, ex_bad, ex_ov, ex_store;
    logic                  n_o_ov, n_o_bad;
    logic [15:0]           n_o_val;

    logic                  r_o_valid;
    logic                  r_o_ov, r_o_halt, r_o_bad;
    logic [15:0]           r_o_val, r_o_acc;
    logic [6:0]            r_o_pc;

    lmc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAILBOXES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    assign mem_q = r_fwd_hit ? r_fwd_data : (r_rd_vld ? ram_q : '0);

    assign out_free = !r_o_valid || i_m_tready;
    assign go_oper  = (r_state == S_FETCH) && (r_req == REQ_STEP) && !r_halt;
    assign done     = ((r_state == S_FETCH) && !go_oper && out_free)
                   || ((r_state == S_OPER) && out_free);
    assign in_ready = (r_state == S_IDLE) || done;
    assign accept   = i_s_tvalid && in_ready;
    assign re       = !((r_state == S_OPER) && !out_free);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_FETCH;
            end
            S_FETCH: begin
                if (go_oper) begin
                    n_state = S_OPER;
                end else if (done) begin
                    n_state = i_s_tvalid ? S_FETCH : S_IDLE;
                end
            end
            S_OPER: begin
                if (done) n_state = i_s_tvalid ? S_FETCH : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Decimal decode: the opcode is the hundreds digit, found by a reciprocal multiply
    // that is exact for values below one thousand.
    always_comb begin
        dec_ins  = mem_q[9:0];
        dec_prod = 16'(dec_ins) * 16'(DIV100_MUL);
        dec_op   = dec_prod[DIV100_SHIFT+3:DIV100_SHIFT];
        dec_rem  = dec_ins - 10'(dec_op) * 10'(DIGIT_BASE);
        dec_a    = dec_rem[6:0];
        dec_a_ok = dec_a < MAILBOXES;
        dec_bad  = mem_q[WORD_BITS-1] || (mem_q >= WORD_BITS'(INS_LIMIT));
    end

    always_comb begin
        opnd     = r_a_ok ? mem_q : '0;
        seq_pc   = (r_pc == ADDR_W'(MAILBOXES - 1)) ? '0 : r_pc + 1'b1;
        tgt_pc   = r_a_ok ? ADDR_W'(r_a) : '0;
        ex_acc   = r_acc;
        ex_pc    = seq_pc;
        ex_halt  = r_halt;
        ex_bad   = r_dec_bad;
        ex_ov    = 1'b0;
        ex_store = 1'b0;
        if (!r_dec_bad) begin
            unique case (r_op)
                OP_HLT: begin
                    if (r_a == ADDR_HALT) ex_halt = 1'b1;
                    else ex_bad = 1'b1;
                end
                OP_ADD: ex_acc = r_acc + opnd;
                OP_SUB: ex_acc = r_acc - opnd;
                OP_STA: ex_store = r_a_ok;
                OP_LDA: ex_acc = opnd;
                OP_BRA: ex_pc = tgt_pc;
                OP_BRZ: begin
                    if (r_acc == '0) ex_pc = tgt_pc;
                end
                OP_BRP: begin
                    if (!r_acc[WORD_BITS-1]) ex_pc = tgt_pc;
                end
                OP_IO: begin
                    if (r_a == ADDR_INPUT) ex_acc = WORD_BITS'(r_word);
                    else if (r_a == ADDR_OUTPUT) ex_ov = 1'b1;
                    else ex_bad = 1'b1;
                end
                default: ex_bad = 1'b1;
            endcase
        end

        n_acc   = r_acc;
        n_pc    = r_pc;
        n_halt  = r_halt;
        n_o_ov  = 1'b0;
        n_o_val = '0;
        n_o_bad = 1'b0;
        we      = 1'b0;
        waddr   = '0;
        wdata   = '0;
        if (done && (r_state == S_FETCH)) begin
            if (r_req == REQ_START) begin
                n_acc  = '0;
                n_pc   = '0;
                n_halt = 1'b0;
            end
            if ((r_req == REQ_LOAD) && (r_box < MAILBOXES)) begin
                we    = 1'b1;
                waddr = ADDR_W'(r_box);
                wdata = WORD_BITS'(r_word);
            end
        end else if (done && (r_state == S_OPER)) begin
            n_acc   = ex_acc;
            n_pc    = ex_pc;
            n_halt  = ex_halt;
            n_o_ov  = ex_ov;
            n_o_val = ex_ov ? 16'(r_acc) : '0;
            n_o_bad = ex_bad;
            we      = ex_store;
            waddr   = ADDR_W'(r_a);
            wdata   = r_acc;
        end

        raddr = go_oper ? (dec_a_ok ? ADDR_W'(dec_a) : '0) : n_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc     <= '0;
            r_pc      <= '0;
            r_halt    <= 1'b0;
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            if (we) r_vld[waddr] <= 1'b1;
            if (done) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_s_tuser;
            r_box  <= i_s_tdata[6:0];
            r_word <= i_s_tdata[22:7];
        end
        if (go_oper) begin
            r_op      <= dec_op;
            r_a       <= dec_a;
            r_a_ok    <= dec_a_ok;
            r_dec_bad <= dec_bad;
        end
        if (re) begin
            r_fwd_hit  <= we && (waddr == raddr);
            r_fwd_data <= wdata;
            r_rd_vld   <= r_vld[raddr];
        end
        if (done) begin
            r_o_ov   <= n_o_ov;
            r_o_val  <= n_o_val;
            r_o_halt <= n_halt;
            r_o_bad  <= n_o_bad;
            r_o_pc   <= 7'(n_pc);
            r_o_acc  <= 16'(n_acc);
        end
    end

    assign o_s_tready   = in_ready;
    assign o_m_tvalid   = r_o_valid;
    assign o_m_tuser[0] = r_o_ov;
    assign o_m_tdata    = {7'd0, r_o_acc, r_o_pc, r_o_bad, r_o_halt, r_o_val};

`ifndef SYNTHESIS
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc < MAILBOXES)
        else $error("program counter left the mailbox range");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && (r_state == S_IDLE)))
        else $error("memory write with no item in work");

    a_oper_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OPER) && !out_free) |=> (r_state == S_OPER))
        else $error("operand stage left while the result could not be stored");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> o_m_tvalid)
        else $error("finished item did not present a result");
`endif

endmodule
